[hw/rtl/pfs_pkg.sv]
// pfs_pkg: shared types, constants and datapath command codes for the
// pFound ranking score block. Used by pfs_ctrl, pfs_dp and pfound_ranking_score.
package pfs_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = 5;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [34:0] HALF_Q16 = 35'h8000;

    // register indexes on the APB port
    localparam logic [1:0] REG_P_BREAK   = 2'd0;
    localparam logic [1:0] REG_LABEL_CAP = 2'd1;
    localparam logic [1:0] REG_TOP_N     = 2'd2;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE   = 4'd0;
    localparam op_t OP_PREP   = 4'd1;
    localparam op_t OP_SCAN   = 4'd2;
    localparam op_t OP_PICK   = 4'd3;
    localparam op_t OP_DIV    = 4'd4;
    localparam op_t OP_MUL1   = 4'd5;
    localparam op_t OP_MUL2   = 4'd6;
    localparam op_t OP_MUL3   = 4'd7;
    localparam op_t OP_MUL4   = 4'd8;
    localparam op_t OP_MUL5   = 4'd9;
    localparam op_t OP_FINISH = 4'd10;

    typedef struct packed {
        logic signed [31:0] predicted_score;
        logic signed [15:0] actual_label;
        logic               last_item;
    } item_t;

    typedef struct packed {
        logic [16:0] score;
        logic [8:0]  items_used;
        logic        overflow;
    } result_t;

    typedef struct packed {
        op_t  op;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic div_done;
        logic pos_last;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/pfs_ctrl.sv]
// pfs_ctrl: sequencer for the pFound block; steps the datapath through load,
// selection scan, relevance divide and the cascade multiplies. Uses pfs_pkg.
module pfs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_last,
    output logic             item_ready,
    input  pfs_pkg::status_t status,
    output pfs_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_PICK   = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_MUL1   = 4'd5;
    localparam logic [3:0] ST_MUL2   = 4'd6;
    localparam logic [3:0] ST_MUL3   = 4'd7;
    localparam logic [3:0] ST_MUL4   = 4'd8;
    localparam logic [3:0] ST_MUL5   = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pfs_pkg::OP_NONE;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = item_valid;
                if (item_valid && item_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.op     = pfs_pkg::OP_PREP;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // last compare lands on the edge that leaves this state
                if (status.scan_end)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    cmd.op = pfs_pkg::OP_SCAN;
                end
            end
            ST_PICK:
            begin
                cmd.op     = pfs_pkg::OP_PICK;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MUL1;
                end
                else
                begin
                    cmd.op = pfs_pkg::OP_DIV;
                end
            end
            ST_MUL1:
            begin
                cmd.op     = pfs_pkg::OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = pfs_pkg::OP_MUL2;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.op     = pfs_pkg::OP_MUL3;
                state_next = ST_MUL4;
            end
            ST_MUL4:
            begin
                cmd.op     = pfs_pkg::OP_MUL4;
                state_next = ST_MUL5;
            end
            ST_MUL5:
            begin
                cmd.op     = pfs_pkg::OP_MUL5;
                state_next = status.pos_last ? ST_FINISH : ST_SCAN;
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    cmd.op     = pfs_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/pfs_dp.sv]
// pfs_dp: datapath of the pFound block: item memory, selection scan,
// bit-serial relevance divider, shared 17x17 multiplier, result register. Uses pfs_pkg.
module pfs_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  pfs_pkg::cmd_t     cmd,
    output pfs_pkg::status_t  status,
    input  pfs_pkg::item_t    item,
    input  logic [15:0]       p_break,
    input  logic [14:0]       label_cap,
    input  logic [8:0]        top_n,
    output logic              result_valid,
    input  logic              result_ready,
    output pfs_pkg::result_t  result
);

    localparam int AW = pfs_pkg::ADDR_W;
    localparam int CW = pfs_pkg::CNT_W;

    logic [47:0] mem [pfs_pkg::MAX_ITEMS];

    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] scan_idx_reg;
    logic [pfs_pkg::MAX_ITEMS-1:0] used_reg;

    logic [47:0]   rd_data_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_valid_reg;

    logic [31:0]   best_key_reg;
    logic [15:0]   best_lab_reg;
    logic [AW-1:0] best_idx_reg;
    logic          best_valid_reg;

    logic [30:0]                  div_q_reg;
    logic [14:0]                  div_rem_reg;
    logic [pfs_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [16:0] look_reg;
    logic [16:0] score_reg;
    logic [16:0] rel_reg;
    logic [16:0] f_reg;
    logic [33:0] prod_reg;

    logic              out_valid_reg;
    pfs_pkg::result_t  out_reg;

    logic [31:0] cand_key;
    logic [15:0] cand_lab;
    logic        cand_before;
    logic        cand_take;
    logic [14:0] ml_eff;
    logic [14:0] clamp_v;
    logic [15:0] rem_shift;
    logic        rem_ge;
    logic [16:0] mul_a;
    logic [16:0] mul_b;
    logic [33:0] mul_p;
    logic [34:0] rnd_sum;
    logic [16:0] rnd;
    logic [17:0] score_sum;
    logic [CW-1:0] n_sel;

    // biased compare: keys and labels become unsigned order
    assign cand_key = {~rd_data_reg[47], rd_data_reg[46:16]};
    assign cand_lab = {~rd_data_reg[15], rd_data_reg[14:0]};

    always_comb
    begin
        if (cand_key != best_key_reg)
        begin
            cand_before = (cand_key > best_key_reg);
        end
        else
        begin
            cand_before = (cand_lab < best_lab_reg);
        end
    end

    assign cand_take = rd_valid_reg && !used_reg[rd_idx_reg]
                       && (!best_valid_reg || cand_before);

    assign ml_eff = (label_cap == 15'd0) ? 15'd1 : label_cap;

    // clamp the chosen label to [0, label cap]; best_lab_reg is biased
    always_comb
    begin
        if (!best_lab_reg[15])
        begin
            clamp_v = 15'd0;
        end
        else if (best_lab_reg[14:0] > ml_eff)
        begin
            clamp_v = ml_eff;
        end
        else
        begin
            clamp_v = best_lab_reg[14:0];
        end
    end

    assign rem_shift = {div_rem_reg, div_q_reg[30]};
    assign rem_ge    = (rem_shift >= {1'b0, ml_eff});

    always_comb
    begin
        mul_a = look_reg;
        mul_b = rel_reg;
        unique case (cmd.op)
            pfs_pkg::OP_MUL1:
            begin
                // take rel from the divider before it is registered
                mul_a = look_reg;
                mul_b = div_q_reg[16:0];
            end
            pfs_pkg::OP_MUL2:
            begin
                mul_a = pfs_pkg::ONE_Q16 - rel_reg;
                mul_b = pfs_pkg::ONE_Q16 - {1'b0, p_break};
            end
            pfs_pkg::OP_MUL4:
            begin
                mul_a = look_reg;
                mul_b = f_reg;
            end
            default:
            begin
                mul_a = look_reg;
                mul_b = rel_reg;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign rnd_sum   = {1'b0, prod_reg} + pfs_pkg::HALF_Q16;
    assign rnd       = rnd_sum[32:16];
    assign score_sum = {1'b0, score_reg} + {1'b0, rnd};

    assign n_sel = ((top_n == 9'd0) || (CW'(top_n) > count_reg)) ? count_reg : CW'(top_n);

    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CW'(pfs_pkg::MAX_ITEMS)))
        begin
            mem[count_reg[AW-1:0]] <= {item.predicted_score, item.actual_label};
        end
        if (cmd.op == pfs_pkg::OP_SCAN)
        begin
            rd_data_reg <= mem[scan_idx_reg[AW-1:0]];
            rd_idx_reg  <= scan_idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            n_reg          <= '0;
            pos_reg        <= '0;
            scan_idx_reg   <= '0;
            used_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (cmd.op == pfs_pkg::OP_SCAN);
            if (cmd.load)
            begin
                if (count_reg < CW'(pfs_pkg::MAX_ITEMS))
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cand_take)
            begin
                best_valid_reg <= 1'b1;
            end
            // a new result may land on the edge that transfers the old one
            out_valid_reg <= (cmd.op == pfs_pkg::OP_FINISH)
                             || (out_valid_reg && !result_ready);
            unique case (cmd.op)
                pfs_pkg::OP_PREP:
                begin
                    n_reg          <= n_sel;
                    pos_reg        <= '0;
                    scan_idx_reg   <= '0;
                    used_reg       <= '0;
                    best_valid_reg <= 1'b0;
                end
                pfs_pkg::OP_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                pfs_pkg::OP_PICK:
                begin
                    used_reg[best_idx_reg] <= 1'b1;
                    best_valid_reg         <= 1'b0;
                    scan_idx_reg           <= '0;
                    div_cnt_reg            <= '0;
                end
                pfs_pkg::OP_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + pfs_pkg::DIV_CNT_W'(1);
                end
                pfs_pkg::OP_MUL5:
                begin
                    pos_reg <= pos_reg + CW'(1);
                end
                pfs_pkg::OP_FINISH:
                begin
                    count_reg     <= '0;
                    dropped_reg   <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_take)
        begin
            best_key_reg <= cand_key;
            best_lab_reg <= cand_lab;
            best_idx_reg <= rd_idx_reg;
        end
        unique case (cmd.op)
            pfs_pkg::OP_PREP:
            begin
                look_reg  <= pfs_pkg::ONE_Q16;
                score_reg <= '0;
            end
            pfs_pkg::OP_PICK:
            begin
                div_q_reg   <= {clamp_v, 2'b00, ml_eff[14:1]};
                div_rem_reg <= '0;
            end
            pfs_pkg::OP_DIV:
            begin
                div_rem_reg <= rem_ge ? 15'(rem_shift - {1'b0, ml_eff}) : rem_shift[14:0];
                div_q_reg   <= {div_q_reg[29:0], rem_ge};
            end
            pfs_pkg::OP_MUL1:
            begin
                rel_reg  <= div_q_reg[16:0];
                prod_reg <= mul_p;
            end
            pfs_pkg::OP_MUL2:
            begin
                score_reg <= (score_sum > {1'b0, pfs_pkg::ONE_Q16}) ? pfs_pkg::ONE_Q16
                                                                     : score_sum[16:0];
                prod_reg  <= mul_p;
            end
            pfs_pkg::OP_MUL3:
            begin
                f_reg <= rnd;
            end
            pfs_pkg::OP_MUL4:
            begin
                prod_reg <= mul_p;
            end
            pfs_pkg::OP_MUL5:
            begin
                look_reg <= rnd;
            end
            pfs_pkg::OP_FINISH:
            begin
                out_reg.score      <= score_reg;
                out_reg.items_used <= 9'(n_reg);
                out_reg.overflow   <= dropped_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.scan_end = (scan_idx_reg == count_reg);
    assign status.div_done = (div_cnt_reg == pfs_pkg::DIV_CNT_W'(pfs_pkg::DIV_STEPS));
    assign status.pos_last = ((pos_reg + CW'(1)) == n_reg);
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(pfs_pkg::MAX_ITEMS))
        else $error("item count above capacity");

    a_pick_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pfs_pkg::OP_PICK |-> best_valid_reg)
        else $error("pick without a selected item");

    a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pfs_pkg::OP_MUL1 |-> div_cnt_reg == pfs_pkg::DIV_CNT_W'(pfs_pkg::DIV_STEPS))
        else $error("cascade started before divide finished");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pfs_pkg::OP_MUL1 |-> pos_reg < n_reg)
        else $error("cascade position past item count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pfs_pkg::OP_FINISH |-> !out_valid_reg || result_ready)
        else $error("result overwritten before transfer");
`endif

endmodule

[hw/rtl/pfound_ranking_score.sv]
// pfound_ranking_score: top level; holds the APB configuration registers and
// joins pfs_ctrl and pfs_dp. Uses pfs_pkg.
//
// Usage:
//   Items arrive on item/item_valid/item_ready, one transfer per cycle while
//   the block is loading. Each item is written to a 256-entry store; items past
//   capacity are dropped and flagged. An item with last_item set closes the
//   list and starts scoring; item_ready stays low until scoring is done.
//   Scoring selects the next best item by one full scan of the stored list,
//   divides its label by the label cap bit-serially and runs the cascade
//   steps MUL1 to MUL5 on the shared multiplier, once for each scored item.
//   The result (score, items_used, overflow) sits in an output register on
//   result/result_valid/result_ready; a new list loads while it waits, and
//   a finished score holds until the receiver takes the pending one.
//   Reset clears the list and the pending result and loads register defaults:
//   p_break 9830, label cap 1024, top_n 0. Write registers only while idle.
module pfound_ranking_score
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  pfs_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output pfs_pkg::result_t  result
);

    logic [15:0] p_break_reg;
    logic [14:0] label_cap_reg;
    logic [8:0]  top_n_reg;
    logic        wr_en;

    pfs_pkg::cmd_t    cmd;
    pfs_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_break_reg   <= 16'd9830;
            label_cap_reg <= 15'd1024;
            top_n_reg     <= 9'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                pfs_pkg::REG_P_BREAK:   p_break_reg   <= pwdata[15:0];
                pfs_pkg::REG_LABEL_CAP: label_cap_reg <= pwdata[14:0];
                pfs_pkg::REG_TOP_N:     top_n_reg     <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pfs_pkg::REG_P_BREAK:   prdata = {16'd0, p_break_reg};
            pfs_pkg::REG_LABEL_CAP: prdata = {17'd0, label_cap_reg};
            pfs_pkg::REG_TOP_N:     prdata = {23'd0, top_n_reg};
            default:                prdata = 32'd0;
        endcase
    end

    pfs_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last_item),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    pfs_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .p_break      (p_break_reg),
        .label_cap    (label_cap_reg),
        .top_n        (top_n_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[bench/pfound_ranking_score_test.sv]
// pfound_ranking_score_test: self-checking bench for the pFound ranking score block.
// Drives ranked lists and APB register writes, and predicts each list's score.
// Depends on pfs_pkg and pfound_ranking_score.
`timescale 1ns / 100ps

module pfound_ranking_score_test;

    localparam int IDLE_LIMIT = 400000;
    localparam int STORE_DEPTH = 256;

    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [3:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             item_valid;
    logic             item_ready;
    pfs_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    pfs_pkg::result_t result;

    pfound_ranking_score DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    // bench copy of the registers and the list being loaded
    logic [15:0] cur_p_break;
    logic [14:0] cur_label_cap;
    logic [8:0]  cur_top_n;
    logic [31:0] list_key [STORE_DEPTH];
    logic [15:0] list_lab [STORE_DEPTH];
    int          list_len;
    logic        list_dropped;

    pfs_pkg::item_t   pending_items[$];
    pfs_pkg::result_t scores_due[$];
    int      errors;
    int      idle_cycles;
    int      in_gap;
    int      out_gap;
    bit      calm;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // sort, truncate and run the cascade over the loaded list
    function automatic pfs_pkg::result_t pfound_of_list();
        logic [31:0] k [STORE_DEPTH];
        logic [15:0] l [STORE_DEPTH];
        logic [31:0] tk;
        logic [15:0] tl;
        longint unsigned look, total, rel, f, v, ml;
        int n, i, j;
        pfs_pkg::result_t r;
        for (i = 0; i < list_len; i++)
        begin
            tk = list_key[i];
            tl = list_lab[i];
            j = i;
            while (j > 0 && (tk != k[j-1] ? tk > k[j-1] : tl < l[j-1]))
            begin
                k[j] = k[j-1];
                l[j] = l[j-1];
                j--;
            end
            k[j] = tk;
            l[j] = tl;
        end
        n = cur_top_n;
        if (n == 0 || n > list_len)
            n = list_len;
        ml = (cur_label_cap == 0) ? 1 : cur_label_cap;
        look = 65536;
        total = 0;
        for (i = 0; i < n; i++)
        begin
            v = (l[i] < 16'h8000) ? 0 : l[i] - 16'h8000;
            if (v > ml)
                v = ml;
            rel = ((v << 16) + (ml >> 1)) / ml;
            total += (look * rel + 32768) >> 16;
            if (total > 65536)
                total = 65536;
            f = ((65536 - rel) * (65536 - cur_p_break) + 32768) >> 16;
            look = (look * f + 32768) >> 16;
        end
        r.score = total[16:0];
        r.items_used = n[8:0];
        r.overflow = list_dropped;
        return r;
    endfunction

    task automatic take_item(input pfs_pkg::item_t it);
        if (list_len < STORE_DEPTH)
        begin
            list_key[list_len] = it.predicted_score ^ 32'h8000_0000;
            list_lab[list_len] = it.actual_label ^ 16'h8000;
            list_len++;
        end
        else
            list_dropped = 1'b1;
        if (it.last_item)
        begin
            scores_due.push_back(pfound_of_list());
            list_len = 0;
            list_dropped = 1'b0;
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("error: %s got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            in_gap <= 0;
        end
        else
        begin
            int w;
            pfs_pkg::item_t nxt;
            if (item_valid && item_ready)
            begin
                take_item(item);
                w = draw_gap();
                if (w == 0 && pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    item <= nxt;
                end
                else
                begin
                    item_valid <= 1'b0;
                    in_gap <= w;
                end
            end
            else if (!item_valid)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    item <= nxt;
                    item_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            int w;
            pfs_pkg::result_t want;
            if (result_valid && result_ready)
            begin
                if (scores_due.size() == 0)
                    report("unexpected result, score", result.score, -1);
                else
                begin
                    want = scores_due.pop_front();
                    if (result.score !== want.score)
                        report("score", result.score, want.score);
                    if (result.items_used !== want.items_used)
                        report("items_used", result.items_used, want.items_used);
                    if (result.overflow !== want.overflow)
                        report("overflow", result.overflow, want.overflow);
                end
                w = draw_gap();
                result_ready <= (w == 0);
                out_gap <= w;
            end
            else if (!result_ready)
            begin
                if (out_gap <= 1)
                    result_ready <= 1'b1;
                out_gap <= out_gap - 1;
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("pfound_ranking_score: mismatch");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pfs_pkg::REG_P_BREAK:   cur_p_break = val[15:0];
            pfs_pkg::REG_LABEL_CAP: cur_label_cap = val[14:0];
            pfs_pkg::REG_TOP_N:     cur_top_n = val[8:0];
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [31:0] p, input logic [15:0] lb, input logic lst);
        pfs_pkg::item_t it;
        it.predicted_score = p;
        it.actual_label = lb;
        it.last_item = lst;
        pending_items.push_back(it);
    endtask

    // random list; labels mostly near the label range, scores often tied
    task automatic push_list(input int len);
        logic [31:0] p;
        logic [15:0] lb;
        int i;
        for (i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0: p = $urandom;
                1: p = $urandom_range(0, 3) - 1;
                default: p = $urandom_range(0, 7) << 14;
            endcase
            case ($urandom_range(0, 4))
                0: lb = $urandom;
                1: lb = -$urandom_range(1, 300);
                default: lb = $urandom_range(0, cur_label_cap + 20);
            endcase
            push_item(p, lb, i == len - 1);
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || item_valid || scores_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int ph, i;
        errors = 0;
        idle_cycles = 0;
        calm = 0;
        list_len = 0;
        list_dropped = 1'b0;
        cur_p_break = 16'd9830;
        cur_label_cap = 15'd1024;
        cur_top_n = 9'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed lists at reset settings
        push_item(32'h7FFF_FFFF, 16'h7FFF, 1'b1);
        push_item(32'h8000_0000, 16'h8000, 1'b1);
        push_item(32'h0001_0000, 16'h0100, 1'b0);
        push_item(32'h0001_0000, 16'h0400, 1'b0);
        push_item(32'h0001_0000, 16'hFFFF, 1'b0);
        push_item(32'h0002_0000, 16'h0000, 1'b0);
        push_item(32'hFFFF_FFFF, 16'h0200, 1'b1);
        push_item(32'h8000_0000, 16'h0400, 1'b0);
        push_item(32'h7FFF_FFFF, 16'h0401, 1'b0);
        push_item(32'h0000_0000, 16'h7FFF, 1'b0);
        push_item(32'h0000_0000, 16'h8000, 1'b1);
        push_item(32'h5555_5555, 16'h5555, 1'b0);
        push_item(32'hAAAA_AAAA, 16'hAAAA, 1'b1);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin reg_write(pfs_pkg::REG_P_BREAK, 0);
                         reg_write(pfs_pkg::REG_LABEL_CAP, 1);
                         reg_write(pfs_pkg::REG_TOP_N, 0); end
                1: begin reg_write(pfs_pkg::REG_P_BREAK, 65535);
                         reg_write(pfs_pkg::REG_LABEL_CAP, 32767);
                         reg_write(pfs_pkg::REG_TOP_N, 256); end
                2: begin reg_write(pfs_pkg::REG_LABEL_CAP, 0);
                         reg_write(pfs_pkg::REG_TOP_N, 1); end
                3: begin reg_write(pfs_pkg::REG_TOP_N, 3);
                         reg_write(pfs_pkg::REG_LABEL_CAP, 1024); end
                4: begin reg_write(pfs_pkg::REG_TOP_N, 0);
                         reg_write(pfs_pkg::REG_P_BREAK, 9830); end
                5: reg_write(pfs_pkg::REG_TOP_N, 511);
                default: begin
                    reg_write(pfs_pkg::REG_P_BREAK, $urandom);
                    reg_write(pfs_pkg::REG_LABEL_CAP, $urandom_range(1, 32767));
                    reg_write(pfs_pkg::REG_TOP_N, $urandom_range(0, 12));
                end
            endcase
            calm = (ph % 3 == 2);
            if (ph == 3)
                push_list(259);     // past capacity: drops and flags
            if (ph == 4)
                push_list(256);     // exactly full, all scored
            for (i = 0; i < 6; i++)
                push_list($urandom_range(0, 9) == 0 ? $urandom_range(12, 30)
                                                    : $urandom_range(1, 8));
            drain();
        end

        if (errors == 0)
            $display("pfound_ranking_score: match");
        else
            $display("pfound_ranking_score: mismatch");
        $finish;
    end

endmodule

[pfound_ranking_score.f]
hw/rtl/pfs_pkg.sv
hw/rtl/pfs_ctrl.sv
hw/rtl/pfs_dp.sv
hw/rtl/pfound_ranking_score.sv
bench/pfound_ranking_score_test.sv
